FILE: hw/rtl/wgm_pkg.sv
// Shared types, constants and microcode for the wildcard glob matcher.
// No dependencies; imported by wildcard_glob_matcher_top.
`default_nettype none
package wgm_pkg;

    localparam int PAT_DEPTH = 64;
    localparam int SUB_DEPTH = 256;
    localparam int PAT_AW    = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
    localparam int SUB_AW    = (SUB_DEPTH > 1) ? $clog2(SUB_DEPTH) : 1;
    localparam int PAT_LW    = $clog2(PAT_DEPTH + 1);
    localparam int SUB_LW    = $clog2(SUB_DEPTH + 1);
    localparam int CP_W      = SUB_LW + 1;

    localparam logic [7:0] STAR_CODE = 8'h2A;
    localparam logic [7:0] ANY_CODE  = 8'h3F;

    localparam int         CFG_AW           = 3;
    localparam logic [0:0] REG_IGNORE_CASE  = 1'b0;

    typedef enum logic [1:0] {
        T_ALWAYS,
        T_SUB_END,
        T_PAT_END,
        T_PAT_STAR
    } t_test;

    typedef enum logic [2:0] {
        A_NOP,
        A_GLOB,
        A_W_INC,
        A_HIT,
        A_MISS
    } t_act;

    typedef enum logic [1:0] {
        U_LOOP_TEST,
        U_LOOP_EVAL,
        U_TRAIL_TEST,
        U_TRAIL_EVAL
    } t_upc;

    typedef struct packed {
        t_test test;
        t_act  act_t;
        t_act  act_f;
        t_upc  jump;
    } t_uword;

    // Each step: on a true test run act_t and jump, else run act_f and fall through.
    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        unique case (pc)
            U_LOOP_TEST:  w = '{T_SUB_END,  A_NOP,   A_NOP,  U_TRAIL_TEST};
            U_LOOP_EVAL:  w = '{T_ALWAYS,   A_GLOB,  A_NOP,  U_LOOP_TEST};
            U_TRAIL_TEST: w = '{T_PAT_END,  A_HIT,   A_NOP,  U_LOOP_TEST};
            U_TRAIL_EVAL: w = '{T_PAT_STAR, A_W_INC, A_MISS, U_TRAIL_TEST};
            default:      w = '{T_ALWAYS,   A_MISS,  A_MISS, U_LOOP_TEST};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        if (ic && c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/wildcard_glob_matcher_top.sv
// Wildcard glob matcher: pattern/subject buffers and a microcoded match walk.
// Depends on wgm_pkg (types, depths, microcode table, case folding).
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+---------------------------
//  input     | i_op, i_ch, i_last, i_empty_req         | start & !busy
//  result    | o_matched, o_overflow                   | o_done, one cycle, no stall
//  config    | psel, penable, pwrite, paddr, pwdata    | APB write, pready tied high
//
// Characters load one per cycle while busy is low. The final subject item starts the
// match walk: each step of the backtracking loop and each trailing star check is a
// test state and then an evaluate state, paced by the registered buffer reads.
// busy is high throughout the walk.
// An overflowed run answers in the cycle after its final item without a walk.
// Synchronous active-low reset clears lengths, status flags and the sequencer; the
// buffers, walk pointers and result flags are not cleared. The result receiver cannot stall.
`default_nettype none
module wildcard_glob_matcher_top
    import wgm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_op,
    input  wire logic [7:0]        i_ch,
    input  wire logic              i_last,
    input  wire logic              i_empty_req,
    output logic                   o_done,
    output logic                   o_matched,
    output logic                   o_overflow,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [7:0] r_pat_mem [PAT_DEPTH];
    logic [7:0] r_sub_mem [SUB_DEPTH];
    logic [7:0] r_pd, r_sd;

    logic              r_ignore_case;
    logic [PAT_LW-1:0] r_pat_len, n_pat_len;
    logic              r_pat_ovf, n_pat_ovf;
    logic              r_pat_closed, n_pat_closed;
    logic [SUB_LW-1:0] r_sub_len, n_sub_len;
    logic              r_sub_ovf, n_sub_ovf;
    logic              r_busy, n_busy;
    t_upc              r_pc, n_pc;
    logic [PAT_LW-1:0] r_w, n_w, r_mp, n_mp;
    logic [SUB_LW-1:0] r_s, n_s;
    logic [CP_W-1:0]   r_cp, n_cp;
    logic              r_star, n_star;
    logic              r_done, n_done;
    logic              r_matched, n_matched;
    logic              r_overflow, n_overflow;

    logic              acc, pat_wr, sub_wr, pat_full, sub_full, tst, run_ovf;
    logic              w_lt, p_star, p_hit;
    logic [PAT_LW-1:0] eff_len, w_inc;
    t_uword            uw;
    t_act              act;

    assign acc      = start && !r_busy;
    assign eff_len  = r_pat_closed ? '0 : r_pat_len;
    assign pat_full = (eff_len >= PAT_LW'(PAT_DEPTH));
    assign sub_full = (r_sub_len >= SUB_LW'(SUB_DEPTH));
    assign pat_wr   = acc && !i_op && !i_empty_req && !pat_full;
    assign sub_wr   = acc && i_op && !i_empty_req && !sub_full;

    // Buffers: one write port from the loader, registered read at the walk pointers.
    always_ff @(posedge i_clk) begin
        if (pat_wr) begin
            r_pat_mem[eff_len[PAT_AW-1:0]] <= i_ch;
        end
        r_pd <= r_pat_mem[r_w[PAT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (sub_wr) begin
            r_sub_mem[r_sub_len[SUB_AW-1:0]] <= i_ch;
        end
        r_sd <= r_sub_mem[r_s[SUB_AW-1:0]];
    end

    assign w_lt   = (r_w < r_pat_len);
    assign w_inc  = r_w + 1'b1;
    assign p_star = w_lt && (r_pd == STAR_CODE);
    assign p_hit  = w_lt && ((r_pd == ANY_CODE) ||
                    (fold(r_pd, r_ignore_case) == fold(r_sd, r_ignore_case)));

    always_comb begin
        uw = ucode(r_pc);
        unique case (uw.test)
            T_ALWAYS:   tst = 1'b1;
            T_SUB_END:  tst = (r_s >= r_sub_len);
            T_PAT_END:  tst = (r_w >= r_pat_len);
            T_PAT_STAR: tst = (r_pd == STAR_CODE);
            default:    tst = 1'b1;
        endcase
        act = tst ? uw.act_t : uw.act_f;
    end

    always_comb begin
        n_pat_len    = r_pat_len;
        n_pat_ovf    = r_pat_ovf;
        n_pat_closed = r_pat_closed;
        n_sub_len    = r_sub_len;
        n_sub_ovf    = r_sub_ovf;
        n_busy       = r_busy;
        n_pc         = r_pc;
        n_w          = r_w;
        n_mp         = r_mp;
        n_s          = r_s;
        n_cp         = r_cp;
        n_star       = r_star;
        n_done       = 1'b0;
        n_matched    = r_matched;
        n_overflow   = r_overflow;
        run_ovf      = 1'b0;

        if (acc && !i_op) begin
            // A pattern item after a closed pattern starts a fresh one.
            n_pat_len    = eff_len + PAT_LW'(pat_wr);
            n_pat_ovf    = (r_pat_closed ? 1'b0 : r_pat_ovf) || (!i_empty_req && pat_full);
            n_pat_closed = i_last;
        end

        if (acc && i_op) begin
            n_pat_closed = 1'b1;
            n_sub_len    = r_sub_len + SUB_LW'(sub_wr);
            n_sub_ovf    = r_sub_ovf || (!i_empty_req && sub_full);
            if (i_last) begin
                run_ovf = n_sub_ovf || r_pat_ovf;
                if (run_ovf) begin
                    n_done     = 1'b1;
                    n_matched  = 1'b0;
                    n_overflow = 1'b1;
                    n_sub_len  = '0;
                    n_sub_ovf  = 1'b0;
                end else begin
                    n_busy = 1'b1;
                    n_pc   = U_LOOP_TEST;
                    n_w    = '0;
                    n_s    = '0;
                    n_mp   = '0;
                    n_cp   = '0;
                    n_star = 1'b0;
                end
            end
        end

        if (r_busy) begin
            n_pc = tst ? uw.jump : t_upc'(r_pc + 1'b1);
            unique case (act)
                A_NOP: begin
                end
                A_GLOB: begin
                    priority if (p_star) begin
                        if (w_inc >= r_pat_len) begin
                            n_busy    = 1'b0;
                            n_done    = 1'b1;
                            n_matched = 1'b1;
                        end else begin
                            n_w    = w_inc;
                            n_mp   = w_inc;
                            n_cp   = CP_W'(r_s) + 1'b1;
                            n_star = 1'b1;
                        end
                    end else if (p_hit) begin
                        n_w = w_inc;
                        n_s = r_s + 1'b1;
                    end else if (!r_star) begin
                        n_busy    = 1'b0;
                        n_done    = 1'b1;
                        n_matched = 1'b0;
                    end else begin
                        // Back to the last star, one subject character further on.
                        n_w  = r_mp;
                        n_s  = r_cp[SUB_LW-1:0];
                        n_cp = r_cp + 1'b1;
                    end
                end
                A_W_INC: n_w = w_inc;
                A_HIT: begin
                    n_busy    = 1'b0;
                    n_done    = 1'b1;
                    n_matched = 1'b1;
                end
                A_MISS: begin
                    n_busy    = 1'b0;
                    n_done    = 1'b1;
                    n_matched = 1'b0;
                end
                default: begin
                    n_busy    = 1'b0;
                    n_done    = 1'b1;
                    n_matched = 1'b0;
                end
            endcase
            if (n_done) begin
                n_overflow = 1'b0;
                n_sub_len  = '0;
                n_sub_ovf  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len    <= '0;
            r_pat_ovf    <= 1'b0;
            r_pat_closed <= 1'b0;
            r_sub_len    <= '0;
            r_sub_ovf    <= 1'b0;
            r_busy       <= 1'b0;
            r_pc         <= U_LOOP_TEST;
            r_done       <= 1'b0;
            r_star       <= 1'b0;
        end else begin
            r_pat_len    <= n_pat_len;
            r_pat_ovf    <= n_pat_ovf;
            r_pat_closed <= n_pat_closed;
            r_sub_len    <= n_sub_len;
            r_sub_ovf    <= n_sub_ovf;
            r_busy       <= n_busy;
            r_pc         <= n_pc;
            r_done       <= n_done;
            r_star       <= n_star;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_mp       <= n_mp;
        r_s        <= n_s;
        r_cp       <= n_cp;
        r_matched  <= n_matched;
        r_overflow <= n_overflow;
    end

    // Configuration: single register, decoded on the word address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_case <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[CFG_AW-1:2] == REG_IGNORE_CASE)) begin
            r_ignore_case <= pwdata[0];
        end
    end

    assign prdata     = (paddr[CFG_AW-1:2] == REG_IGNORE_CASE) ? {31'b0, r_ignore_case} : '0;
    assign pready     = 1'b1;
    assign busy       = r_busy;
    assign o_done     = r_done;
    assign o_matched  = r_matched;
    assign o_overflow = r_overflow;

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_matched && o_overflow))
        else $error("matched and overflow both set");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("result given while walk still running");

    a_ovf_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_op && i_last && run_ovf) |=> (o_done && o_overflow))
        else $error("overflowed run not answered at once");

    a_w_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_w <= r_pat_len && r_s <= r_sub_len))
        else $error("walk pointer beyond stored length");

endmodule
`default_nettype wire
